>>> rtl/core/dense_shortest_path_engine_macros.svh
// assertion helpers
`ifndef DENSE_SHORTEST_PATH_ENGINE_MACROS_SVH
`define DENSE_SHORTEST_PATH_ENGINE_MACROS_SVH
`define DSP_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
`define DSP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`endif

>>> rtl/core/dsp_pkg.sv
`default_nettype none
package dsp_pkg;
	localparam int DIST_BITS = 20;
	localparam logic [DIST_BITS-1:0] DIST_MAX = '1;
	localparam logic [1:0] ACT_WRITE  = 2'd0;
	localparam logic [1:0] ACT_CLEAR  = 2'd1;
	localparam logic [1:0] ACT_RUN    = 2'd2;
	localparam logic [1:0] ACT_UNUSED = 2'd3;
	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_CLEAR = 7'b0000010,
		ST_INIT  = 7'b0000100,
		ST_RDW   = 7'b0001000,
		ST_SCAN  = 7'b0010000,
		ST_RELAX = 7'b0100000,
		ST_EMIT  = 7'b1000000
	} state_t;
endpackage
`default_nettype wire

>>> rtl/core/dense_shortest_path_engine.sv
`default_nettype none
// channel | valid    | ready    | payload
// in      | valid    | ready    | action from_node to_node edge_cost edge_absent start_node
// out     | out_valid| out_ready| node distance predecessor reachable last
// cfg     | cfg_we   | -        | cfg_data (node_count)
// Edge write: stored when the word is accepted. Clear: one matrix entry a cycle.
// Run: load the start row, then per round an n-entry scan, a pick and an n-entry relax pass;
// the first result word follows the last round, sooner on an early stop.
// Then n-1 result words, one per accepted output word.
// Reset: asynchronous; the matrix is swept to absent after reset.
// Stalls on the output hold the emit sequencer; input is not taken while busy.
module dense_shortest_path_engine import dsp_pkg::*; #(
	parameter int MAX_NODES = 16,
	parameter int COST_BITS = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic [4:0] cfg_data,
	input  wire logic valid,
	output logic ready,
	input  wire logic [1:0] action,
	input  wire logic [3:0] from_node,
	input  wire logic [3:0] to_node,
	input  wire logic [15:0] edge_cost,
	input  wire logic edge_absent,
	input  wire logic [3:0] start_node,
	output logic out_valid,
	input  wire logic out_ready,
	output logic [3:0] node,
	output logic [DIST_BITS-1:0] distance,
	output logic [3:0] predecessor,
	output logic reachable,
	output logic last
);
	localparam int IB = $clog2(MAX_NODES);
	localparam int AB = 2 * IB;
	localparam int NB = IB + 1;
	localparam logic [COST_BITS-1:0] CMAX = '1;

	logic [COST_BITS:0] mem [MAX_NODES*MAX_NODES];
	logic [COST_BITS:0] rd_q;
	logic [4:0] ncfg_q;
	state_t st_q;
	logic [AB-1:0] clr_q;
	logic [IB-1:0] s_q, w_q, k_q, kr_q, best_q;
	logic found_q;
	logic [DIST_BITS-1:0] bd_q;
	logic [NB-1:0] n_q;
	logic [IB:0] rnd_q;
	logic rdv_q;

	logic [DIST_BITS-1:0] node_dist [MAX_NODES];
	logic [IB-1:0] par [MAX_NODES];
	logic inf [MAX_NODES];
	logic done [MAX_NODES];

	logic acc, we;
	logic [AB-1:0] wa, ra;
	logic [COST_BITS:0] wd;
	logic [COST_BITS-1:0] csat;
	logic [NB-1:0] nuse;
	logic in_rng;
	logic [IB-1:0] last_idx;

	assign acc = valid && ready;
	assign ready = (st_q == ST_IDLE);
	assign in_rng = (32'(from_node) < MAX_NODES) && (32'(to_node) < MAX_NODES);
	assign csat = (32'(edge_cost) > 32'(CMAX)) ? CMAX : COST_BITS'(edge_cost);

	always_comb begin
		if (ncfg_q < 5'd2) nuse = NB'(2);
		else if (32'(ncfg_q) > MAX_NODES) nuse = NB'(MAX_NODES);
		else nuse = NB'(ncfg_q);
	end

	always_comb begin
		we = 1'b0;
		wa = clr_q;
		wd = {1'b1, {COST_BITS{1'b0}}};
		if (st_q == ST_CLEAR) we = 1'b1;
		else if (acc && action == ACT_WRITE && in_rng) begin
			we = 1'b1;
			wa = {IB'(from_node), IB'(to_node)};
			wd = {edge_absent, csat};
		end
	end
	assign ra = {(st_q == ST_INIT) ? s_q : w_q, k_q};

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		rd_q <= mem[ra];
	end

	logic [IB-1:0] n_last;
	assign n_last = IB'(n_q - NB'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLEAR;
			clr_q <= '0;
			ncfg_q <= 5'd16;
			rdv_q <= 1'b0;
			k_q <= '0;
			kr_q <= '0;
			s_q <= '0;
			w_q <= '0;
			best_q <= '0;
			found_q <= 1'b0;
			bd_q <= '0;
			n_q <= '0;
			rnd_q <= '0;
		end else begin
			if (cfg_we) ncfg_q <= cfg_data;
			rdv_q <= 1'b0;
			kr_q <= k_q;
			case (st_q)
				ST_IDLE: begin
					if (acc && action == ACT_CLEAR) begin
						st_q <= ST_CLEAR;
						clr_q <= '0;
					end else if (acc && action == ACT_RUN && 32'(start_node) < 32'(nuse)) begin
						s_q <= IB'(start_node);
						n_q <= nuse;
						k_q <= '0;
						st_q <= ST_INIT;
					end
				end
				ST_CLEAR: begin
					clr_q <= clr_q + AB'(1);
					if (clr_q == '1) st_q <= ST_IDLE;
				end
				ST_INIT: begin
					rdv_q <= 1'b1;
					if (k_q == n_last) begin
						st_q <= ST_SCAN;
						rnd_q <= (IB+1)'(1);
						found_q <= 1'b0;
						k_q <= '0;
					end else k_q <= k_q + IB'(1);
				end
				ST_SCAN: begin
					if (!done[k_q] && !inf[k_q] && (!found_q || node_dist[k_q] < bd_q)) begin
						found_q <= 1'b1;
						bd_q <= node_dist[k_q];
						best_q <= k_q;
					end
					if (k_q == n_last) begin
						k_q <= '0;
						st_q <= ST_RDW;
					end else k_q <= k_q + IB'(1);
				end
				ST_RDW: begin
					if (!found_q) begin
						st_q <= ST_EMIT;
						k_q <= (s_q == '0) ? IB'(1) : '0;
					end else begin
						w_q <= best_q;
						st_q <= ST_RELAX;
						k_q <= '0;
					end
				end
				ST_RELAX: begin
					rdv_q <= 1'b1;
					if (k_q == n_last) begin
						k_q <= '0;
						found_q <= 1'b0;
						if (32'(rnd_q) + 1 >= 32'(n_q)) begin
							st_q <= ST_EMIT;
							k_q <= (s_q == '0) ? IB'(1) : '0;
						end else begin
							rnd_q <= rnd_q + (IB+1)'(1);
							st_q <= ST_SCAN;
						end
					end else k_q <= k_q + IB'(1);
				end
				ST_EMIT: begin
					if (!rdv_q && out_ready) begin
						if (k_q == last_idx) st_q <= ST_IDLE;
						else if (k_q + IB'(1) == s_q) k_q <= k_q + IB'(2);
						else k_q <= k_q + IB'(1);
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	logic init_s1, relax_s1;
	logic [IB-1:0] wsrc_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_s1 <= 1'b0;
			relax_s1 <= 1'b0;
		end else begin
			init_s1 <= (st_q == ST_INIT);
			relax_s1 <= (st_q == ST_RELAX);
		end
	end
	always_ff @(posedge clk) wsrc_s1 <= (st_q == ST_INIT) ? s_q : w_q;

	assign last_idx = (s_q == n_last) ? IB'(n_last - IB'(1)) : n_last;

	genvar g;
	generate
		for (g = 0; g < MAX_NODES; g++) begin : g_cell
			logic sel, st_settle;
			assign sel = (init_s1 || relax_s1) && (kr_q == IB'(g));
			assign st_settle = (init_s1 && sel && (s_q == IB'(g)))
				|| (st_q == ST_RDW && found_q && best_q == IB'(g));
			dsp_cell #(.COST_BITS(COST_BITS), .IDX_BITS(IB)) u_cell (
				.clk(clk), .arst_n(arst_n),
				.init(init_s1 && sel), .relax(relax_s1 && sel), .settle(st_settle),
				.w_idx(wsrc_s1), .w_dist(init_s1 ? '0 : node_dist[w_q]),
				.cost(rd_q[COST_BITS-1:0]), .absent(rd_q[COST_BITS]),
				.cur_dist(node_dist[g]), .parent(par[g]), .inf(inf[g]), .done(done[g]));
		end
	endgenerate

	assign out_valid = (st_q == ST_EMIT) && !rdv_q;
	assign node = 4'(k_q);
	assign reachable = !inf[k_q];
	assign distance = inf[k_q] ? '0 : node_dist[k_q];
	assign predecessor = inf[k_q] ? 4'(s_q) : 4'(par[k_q]);
	assign last = (k_q == last_idx);
endmodule
`default_nettype wire

>>> rtl/core/dsp_cell.sv
`default_nettype none
// One node: holds distance, parent and flags; compares a streamed row entry.
module dsp_cell import dsp_pkg::*; #(
	parameter int COST_BITS = 16,
	parameter int IDX_BITS = 4
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic init,
	input  wire logic relax,
	input  wire logic settle,
	input  wire logic [IDX_BITS-1:0] w_idx,
	input  wire logic [DIST_BITS-1:0] w_dist,
	input  wire logic [COST_BITS-1:0] cost,
	input  wire logic absent,
	output logic [DIST_BITS-1:0] cur_dist,
	output logic [IDX_BITS-1:0] parent,
	output logic inf,
	output logic done
);
	logic [DIST_BITS-1:0] dist_q;
	logic [IDX_BITS-1:0] parent_q;
	logic inf_q, done_q;
	logic [DIST_BITS:0] sum;
	logic [DIST_BITS-1:0] sat;
	assign sum = {1'b0, w_dist} + (DIST_BITS+1)'(cost);
	assign sat = sum[DIST_BITS] ? DIST_MAX : sum[DIST_BITS-1:0];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inf_q <= 1'b1;
			done_q <= 1'b0;
		end else if (init) begin
			inf_q <= absent;
			done_q <= settle;
		end else if (settle) begin
			done_q <= 1'b1;
		end else if (relax && !done_q && !absent && (inf_q || sat < dist_q)) begin
			inf_q <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		if (init) begin
			dist_q <= absent ? '0 : sat;
			parent_q <= w_idx;
		end else if (relax && !settle && !done_q && !absent && (inf_q || sat < dist_q)) begin
			dist_q <= sat;
			parent_q <= w_idx;
		end
	end
	assign cur_dist = dist_q;
	assign parent = parent_q;
	assign inf = inf_q;
	assign done = done_q;
endmodule
`default_nettype wire

>>> rtl/core/dsp_checker.sv
`default_nettype none
`include "dense_shortest_path_engine_macros.svh"
module dsp_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic valid,
	input wire logic ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic last,
	input wire logic reachable,
	input wire logic [19:0] distance
);
	`DSP_ASSERT_IMPL(a_busy, out_valid, !ready, "input taken during results")
	`DSP_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(last), "word dropped")
	`DSP_ASSERT_IMPL(a_unr, out_valid && !reachable, distance == 20'd0, "unreachable distance")
endmodule
bind dense_shortest_path_engine dsp_checker u_chk (
	.clk(clk), .arst_n(arst_n), .valid(valid), .ready(ready), .out_valid(out_valid),
	.out_ready(out_ready), .last(last), .reachable(reachable), .distance(distance));
`default_nettype wire
